// ===== src/pot_averaging_motor_servo_drive_assert.svh =====
// assertion macros shared by the checker of the potentiometer drive block
// no dependencies; the caller supplies clock, reset and the expressions
`ifndef POT_AVERAGING_MOTOR_SERVO_DRIVE_ASSERT_SVH
`define POT_AVERAGING_MOTOR_SERVO_DRIVE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define PAMSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PAMSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pamsd_pkg.sv =====
// shared types and constants of the potentiometer averaging drive block
// no dependencies; used by every module of the block
`default_nettype none

package pamsd_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 10;
  localparam int unsigned SAMPLE_W       = 10;
  localparam int unsigned PROD_W         = 18;
  localparam int unsigned SPEED_SCALE    = 198;
  localparam int unsigned ANGLE_SCALE    = 180;
  localparam int unsigned ADC_FULL       = 1023;
  localparam int unsigned SPEED_MID      = 99;
  localparam int unsigned ANGLE_MID      = 90;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam logic [15:0] PULSE_MAX      = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTOR_GAIN   = 2'd0,
    REG_SERVO_OFFSET = 2'd1,
    REG_SERVO_GAIN   = 2'd2
  } pamsd_reg_e;

  typedef enum logic [1:0] {
    LANE_IDLE,
    LANE_UPDATE,
    LANE_DIVIDE,
    LANE_DONE
  } pamsd_lane_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] speed_sample;
    logic [SAMPLE_W-1:0] angle_sample;
  } pamsd_in_t;

  typedef struct packed {
    logic signed [7:0] speed_setting;
    logic [6:0]        abs_speed;
    logic signed [7:0] angle_setting;
    logic [7:0]        abs_angle;
    logic              bridge_in1;
    logic              bridge_in2;
    logic [15:0]       motor_pulse;
    logic [15:0]       servo_pulse;
  } pamsd_out_t;

  typedef struct packed {
    logic [9:0]  motor_gain;
    logic [15:0] servo_offset;
    logic [9:0]  servo_gain;
  } pamsd_cfg_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] avg;
  } pamsd_lane_stat_t;

endpackage

`default_nettype wire

// ===== src/pot_averaging_motor_servo_drive.sv =====
// Two-channel potentiometer averaging with motor and servo drive outputs.
// Input channel: in_valid_i / in_stall_o carry one beat with a speed and an
// angle sample. Output channel: out_valid_o / out_stall_i carry one result
// beat per input beat. Registers are written through cfg_valid_i /
// cfg_ready_o with cfg_index_i and cfg_data_i; cfg_ready_o is always high
// and writes are expected only while the block is idle.
// Each sample pair runs through two averaging lanes side by side (window
// update, then a reciprocal-multiply divide) and then a three-stage merge.
// out_valid_o rises after the two lanes, the merge and the output register.
// One item is in flight at a time; in_stall_o drops as it leaves the merge.
// A finished result sits in the output register, and the next input beat is
// taken while it waits; a further result is held in the merge stage, with
// the input stalled, until the receiver drops out_stall_i.
// Reset clears the windows (via per-entry valid bits), sums, write slot,
// config and the busy and valid flags; no clearing pass is needed.
`default_nettype none

module pot_averaging_motor_servo_drive #(
  parameter int unsigned WINDOW_LEN = pamsd_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire pamsd_pkg::pamsd_in_t                in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output pamsd_pkg::pamsd_out_t                    out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [pamsd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pamsd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

  logic                        busy_q;
  logic                        in_fire, take;
  logic [SLOT_W-1:0]           slot_q;
  pamsd_pkg::pamsd_cfg_t       cfg_q;
  pamsd_pkg::pamsd_lane_stat_t speed_stat, angle_stat;
  logic                        res_valid;
  pamsd_pkg::pamsd_out_t       res;
  logic                        out_valid_q;
  pamsd_pkg::pamsd_out_t       out_data_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy_q;
  assign in_fire     = in_valid_i && !busy_q;
  assign take        = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pamsd_pkg::REG_MOTOR_GAIN:   cfg_q.motor_gain   <= cfg_data_i[9:0];
        pamsd_pkg::REG_SERVO_OFFSET: cfg_q.servo_offset <= cfg_data_i;
        pamsd_pkg::REG_SERVO_GAIN:   cfg_q.servo_gain   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
        slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
      end else if (take) begin
        busy_q <= 1'b0;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_data_q <= res;
  end

  pamsd_lane #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_speed_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .sample_i (in_data_i.speed_sample),
    .slot_i   (slot_q),
    .stat_o   (speed_stat)
  );

  pamsd_lane #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_angle_lane (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .sample_i (in_data_i.angle_sample),
    .slot_i   (slot_q),
    .stat_o   (angle_stat)
  );

  pamsd_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .speed_stat_i (speed_stat),
    .angle_stat_i (angle_stat),
    .cfg_i        (cfg_q),
    .take_i       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/pamsd_lane.sv =====
// one averaging lane: sliding window memory, running sum and a division by
// the window length through a reciprocal multiply; uses pamsd_pkg
`default_nettype none

module pamsd_lane #(
  parameter int unsigned WINDOW_LEN = pamsd_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pamsd_pkg::SAMPLE_W-1:0]  sample_i,
  input  wire logic [(WINDOW_LEN > 1 ? $clog2(WINDOW_LEN) : 1)-1:0] slot_i,
  output pamsd_pkg::pamsd_lane_stat_t          stat_o
);

  localparam int unsigned SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned SUM_W   = $clog2(WINDOW_LEN * pamsd_pkg::ADC_FULL + 1);
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW_LEN);
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned MUL_W   = SUM_W + RECIP_W;
  localparam int unsigned SW      = pamsd_pkg::SAMPLE_W;
  // ceil(2^SHIFT / WINDOW_LEN) gives the exact floor for every sum below 2^SUM_W
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  pamsd_pkg::pamsd_lane_e state_q, state_d;

  logic [SW-1:0]         win_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] valid_q;
  logic [SW-1:0]         rd_q;
  logic [SW-1:0]         sample_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [MUL_W-1:0]      prod;
  logic [SW-1:0]         avg_q;
  logic [SW-1:0]         old_val;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pamsd_pkg::LANE_IDLE: begin
        if (start_i) state_d = pamsd_pkg::LANE_UPDATE;
      end
      pamsd_pkg::LANE_UPDATE: begin
        state_d = pamsd_pkg::LANE_DIVIDE;
      end
      pamsd_pkg::LANE_DIVIDE: begin
        state_d = pamsd_pkg::LANE_DONE;
      end
      pamsd_pkg::LANE_DONE: begin
        state_d = pamsd_pkg::LANE_IDLE;
      end
    endcase
  end

  // slots never written since reset count as zero
  assign old_val = valid_q[slot_q] ? rd_q : '0;
  assign sum_d   = sum_q - SUM_W'(old_val) + SUM_W'(sample_q);

  // floor(sum / WINDOW_LEN) is the top part of sum times the reciprocal
  assign prod = MUL_W'(sum_q) * MUL_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pamsd_pkg::LANE_IDLE;
      valid_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == pamsd_pkg::LANE_UPDATE) begin
        sum_q           <= sum_d;
        valid_q[slot_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == pamsd_pkg::LANE_IDLE) begin
      rd_q <= win_mem[slot_i];
    end
    if (state_q == pamsd_pkg::LANE_UPDATE) begin
      win_mem[slot_q] <= sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == pamsd_pkg::LANE_IDLE) begin
      sample_q <= sample_i;
      slot_q   <= slot_i;
    end
    if (state_q == pamsd_pkg::LANE_DIVIDE) begin
      avg_q <= prod[SHIFT +: SW];
    end
  end

  // the average never exceeds a full-scale sample
  assign stat_o.done = (state_q == pamsd_pkg::LANE_DONE);
  assign stat_o.avg  = avg_q;

endmodule

`default_nettype wire

// ===== src/pamsd_merge.sv =====
// merging stage: scales both lane averages, derives direction bits and
// computes the saturated pulse widths; uses pamsd_pkg
`default_nettype none

module pamsd_merge (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pamsd_pkg::pamsd_lane_stat_t speed_stat_i,
  input  wire pamsd_pkg::pamsd_lane_stat_t angle_stat_i,
  input  wire pamsd_pkg::pamsd_cfg_t       cfg_i,
  input  wire logic                        take_i,
  output logic                             res_valid_o,
  output pamsd_pkg::pamsd_out_t            res_o
);

  localparam int unsigned PW = pamsd_pkg::PROD_W;

  // floor(p / 1023) for p below 256*1023: p>>10 plus a single correction
  function automatic logic [7:0] div_full(input logic [PW-1:0] p);
    logic [7:0]  q0;
    logic [10:0] r;
    q0 = p[PW-1:10];
    r  = 11'(p[9:0]) + 11'(q0);
    return q0 + 8'(r >= 11'(pamsd_pkg::ADC_FULL));
  endfunction

  logic              s1_valid_q, s2_valid_q, s3_valid_q;
  logic [PW-1:0]     sprod_q, aprod_q;
  logic [7:0]        sscaled, ascaled;
  logic signed [7:0] speed_setting_q, angle_setting_q;
  logic [6:0]        abs_speed_q;
  logic [7:0]        abs_angle_q;
  logic              neg_q, pos_q;
  logic [16:0]       mprod_q;
  logic [17:0]       vprod_q;
  logic [17:0]       servo_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= speed_stat_i.done && angle_stat_i.done;
      s2_valid_q <= s1_valid_q;
      if (s2_valid_q) begin
        s3_valid_q <= 1'b1;
      end else if (take_i) begin
        s3_valid_q <= 1'b0;
      end
    end
  end

  assign sscaled = div_full(sprod_q);
  assign ascaled = div_full(aprod_q);

  always_ff @(posedge clk_i) begin
    if (speed_stat_i.done && angle_stat_i.done) begin
      sprod_q <= PW'(speed_stat_i.avg) * PW'(pamsd_pkg::SPEED_SCALE);
      aprod_q <= PW'(angle_stat_i.avg) * PW'(pamsd_pkg::ANGLE_SCALE);
    end
    if (s1_valid_q) begin
      speed_setting_q <= $signed(sscaled - 8'(pamsd_pkg::SPEED_MID));
      neg_q           <= (sscaled < 8'(pamsd_pkg::SPEED_MID));
      pos_q           <= (sscaled > 8'(pamsd_pkg::SPEED_MID));
      abs_speed_q     <= (sscaled < 8'(pamsd_pkg::SPEED_MID))
                         ? 7'(8'(pamsd_pkg::SPEED_MID) - sscaled)
                         : 7'(sscaled - 8'(pamsd_pkg::SPEED_MID));
      abs_angle_q     <= ascaled;
      angle_setting_q <= $signed(ascaled - 8'(pamsd_pkg::ANGLE_MID));
    end
    if (s2_valid_q) begin
      mprod_q <= 17'(cfg_i.motor_gain) * 17'(abs_speed_q);
      vprod_q <= 18'(cfg_i.servo_gain) * 18'(abs_angle_q);
    end
  end

  // offset plus largest product still fits in 18 bits
  assign servo_sum = 18'(cfg_i.servo_offset) + vprod_q;

  assign res_valid_o         = s3_valid_q;
  assign res_o.speed_setting = speed_setting_q;
  assign res_o.abs_speed     = abs_speed_q;
  assign res_o.angle_setting = angle_setting_q;
  assign res_o.abs_angle     = abs_angle_q;
  assign res_o.bridge_in1    = neg_q;
  assign res_o.bridge_in2    = pos_q;
  assign res_o.motor_pulse   = (mprod_q[16]) ? pamsd_pkg::PULSE_MAX : mprod_q[15:0];
  assign res_o.servo_pulse   = (servo_sum[17:16] != 2'b00) ? pamsd_pkg::PULSE_MAX
                                                            : servo_sum[15:0];

endmodule

`default_nettype wire

// ===== src/pamsd_checker.sv =====
// port-level checker for the potentiometer drive block, bound to the top
// depends on pamsd_pkg and the assertion macro header
`default_nettype none

`include "pot_averaging_motor_servo_drive_assert.svh"

module pamsd_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire pamsd_pkg::pamsd_out_t            out_data_o
);

  // a taken beat sets in_stall_o, holding off the next input beat
  `PAMSD_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not held off after a beat")

  `PAMSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  `PAMSD_ASSERT_NOW(a_bridge_excl, clk_i, rst_ni, out_valid_o, !(out_data_o.bridge_in1 && out_data_o.bridge_in2), "both bridge inputs high")

  // zero speed means bridge off and no motor pulse
  `PAMSD_ASSERT_NOW(a_zero_speed, clk_i, rst_ni, out_valid_o && out_data_o.abs_speed == 7'd0, !out_data_o.bridge_in1 && !out_data_o.bridge_in2 && out_data_o.motor_pulse == 16'd0, "drive active at zero speed")

endmodule

bind pot_averaging_motor_servo_drive pamsd_checker u_pamsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
